>>> hdl/bakery_ticket_lock_arbiter_macros.svh
// Assertion helpers for the lock arbiter.
`ifndef BAKERY_TICKET_LOCK_ARBITER_MACROS_SVH
`define BAKERY_TICKET_LOCK_ARBITER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BKTL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BKTL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/bktl_pkg.sv
`default_nettype none
package bktl_pkg;

   localparam int MAX_AGENTS_DEF  = 8;
   localparam int TICKET_BITS_DEF = 16;

   localparam int OP_W     = 1;
   localparam int AGENT_W  = 3;
   localparam int STATUS_W = 3;
   localparam int TICKET_W = 16;
   localparam int HOLDER_W = 3;
   localparam int COUNT_W  = 4;
   localparam int CFG_W    = 4;

   localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

   localparam logic [OP_W-1:0] OP_REQUEST = 1'b0;
   localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_AGENT  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ALREADY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NO_TICKET  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_HOLDER = 3'd4;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd5;

   typedef struct packed {
      logic start;
      logic scan;
      logic decide;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

>>> hdl/bktl_channels.sv
`default_nettype none
interface bktl_req_if;
   logic                          valid;
   logic                          ready;
   logic [bktl_pkg::OP_W-1:0]     op;
   logic [bktl_pkg::AGENT_W-1:0]  agent;
   modport source (output valid, output op, output agent, input ready);
   modport sink (input valid, input op, input agent, output ready);
endinterface

interface bktl_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bktl_pkg::STATUS_W-1:0]  status;
   logic [bktl_pkg::TICKET_W-1:0]  ticket;
   logic                           holder_valid;
   logic [bktl_pkg::HOLDER_W-1:0]  holder;
   logic [bktl_pkg::COUNT_W-1:0]   waiting_count;
   modport source (output valid, output status, output ticket, output holder_valid,
                   output holder, output waiting_count, input ready);
   modport sink (input valid, input status, input ticket, input holder_valid,
                 input holder, input waiting_count, output ready);
endinterface

interface bktl_csr_if;
   logic                        valid;
   logic                        ready;
   logic [bktl_pkg::CFG_W-1:0]  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/bktl_ram.sv
`default_nettype none
module bktl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  wire logic                                clock,
   input  wire logic                                we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                    wdata,
   input  wire logic                                re,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output      logic [WIDTH-1:0]                    rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> hdl/bktl_ctrl.sv
`default_nettype none
module bktl_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire bktl_pkg::stat_type stat,
   output      bktl_pkg::cmd_type  cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_LAST   = 2'd2;
   localparam logic [1:0] S_DECIDE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_last) begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (stat.out_free) begin
               cmd.decide = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/bktl_dp.sv
`default_nettype none
module bktl_dp #(
   parameter int MAX_AGENTS  = bktl_pkg::MAX_AGENTS_DEF,
   parameter int TICKET_BITS = bktl_pkg::TICKET_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire bktl_pkg::cmd_type              cmd,
   output      bktl_pkg::stat_type             stat,
   input  wire logic [bktl_pkg::OP_W-1:0]      req_op,
   input  wire logic [bktl_pkg::AGENT_W-1:0]   req_agent,
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [bktl_pkg::CFG_W-1:0]     csr_data,
   input  wire logic                           rsp_ready,
   output      logic                           rsp_valid,
   output      logic [bktl_pkg::STATUS_W-1:0]  rsp_status,
   output      logic [bktl_pkg::TICKET_W-1:0]  rsp_ticket,
   output      logic                           rsp_holder_valid,
   output      logic [bktl_pkg::HOLDER_W-1:0]  rsp_holder,
   output      logic [bktl_pkg::COUNT_W-1:0]   rsp_waiting_count
);

   localparam int AGENT_BITS = $clog2(MAX_AGENTS);
   localparam int CNT_BITS   = $clog2(MAX_AGENTS + 1);
   localparam int IDX_W      = AGENT_BITS > bktl_pkg::AGENT_W ? AGENT_BITS : bktl_pkg::AGENT_W;
   localparam int LIM_W      = CNT_BITS > bktl_pkg::CFG_W ? CNT_BITS : bktl_pkg::CFG_W;
   localparam logic [TICKET_BITS-1:0] TICKET_TOP = {TICKET_BITS{1'b1}};
   localparam logic [AGENT_BITS-1:0]  IDX_LAST   = AGENT_BITS'(MAX_AGENTS - 1);
   localparam logic [LIM_W-1:0]       LIM_MAX    = LIM_W'(MAX_AGENTS);

   logic [bktl_pkg::CFG_W-1:0]   cfg_ff;
   logic [bktl_pkg::OP_W-1:0]    op_ff;
   logic [bktl_pkg::AGENT_W-1:0] agent_ff;
   logic [AGENT_BITS-1:0]        idx_ff;
   logic                         rd_pend_ff;
   logic [AGENT_BITS-1:0]        rd_idx_ff;
   logic                         rd_vld_ff;
   logic [MAX_AGENTS-1:0]        vld_ff;

   logic [TICKET_BITS-1:0] max_ff;
   logic [CNT_BITS-1:0]    cnt_ff;
   logic                   v1_ff;
   logic [TICKET_BITS-1:0] t1_ff;
   logic [AGENT_BITS-1:0]  w1_ff;
   logic                   v2_ff;
   logic [TICKET_BITS-1:0] t2_ff;
   logic [AGENT_BITS-1:0]  w2_ff;
   logic [TICKET_BITS-1:0] own_ff;

   logic                            rsp_valid_ff;
   logic [bktl_pkg::STATUS_W-1:0]   status_ff;
   logic [bktl_pkg::TICKET_W-1:0]   ticket_ff;
   logic                            hv_ff;
   logic [bktl_pkg::HOLDER_W-1:0]   holder_ff;
   logic [bktl_pkg::COUNT_W-1:0]    count_ff;

   logic [TICKET_BITS-1:0] rdata;
   logic [TICKET_BITS-1:0] cur_t;
   logic [AGENT_BITS-1:0]  agent_idx;
   logic                   do_write;
   logic [TICKET_BITS-1:0] wdata;

   logic [LIM_W-1:0]              lim;
   logic [bktl_pkg::STATUS_W-1:0] status_in;
   logic [TICKET_BITS-1:0]        give;
   logic                          hv_in;
   logic [AGENT_BITS-1:0]         hw_in;
   logic [CNT_BITS-1:0]           cnt_in;
   logic [31:0]                   give_wide;
   logic [7:0]                    hw_wide;
   logic [7:0]                    cnt_wide;

   assign agent_idx = AGENT_BITS'(IDX_W'(agent_ff));
   assign cur_t     = rd_vld_ff ? rdata : '0;

   assign stat.scan_last = (idx_ff == IDX_LAST);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready      = 1'b1;

   bktl_ram #(
      .WIDTH (TICKET_BITS),
      .DEPTH (MAX_AGENTS)
   ) u_tickets (
      .clock (clock),
      .we    (cmd.decide && do_write),
      .waddr (agent_idx),
      .wdata (wdata),
      .re    (cmd.scan),
      .raddr (idx_ff),
      .rdata (rdata)
   );

   always_comb begin
      lim       = (LIM_W'(cfg_ff) > LIM_MAX) ? LIM_MAX : LIM_W'(cfg_ff);
      give      = max_ff + TICKET_BITS'(1);
      status_in = bktl_pkg::ST_OK;
      do_write  = 1'b0;
      wdata     = '0;
      hv_in     = v1_ff;
      hw_in     = w1_ff;
      cnt_in    = cnt_ff;
      give_wide = '0;
      priority if (LIM_W'(agent_ff) >= lim) begin
         status_in = bktl_pkg::ST_BAD_AGENT;
      end else if (op_ff == bktl_pkg::OP_REQUEST) begin
         priority if (own_ff != '0) begin
            status_in = bktl_pkg::ST_ALREADY;
         end else if (max_ff == TICKET_TOP) begin
            status_in = bktl_pkg::ST_OVERFLOW;
         end else begin
            do_write  = 1'b1;
            wdata     = give;
            give_wide = 32'(give);
            hv_in     = 1'b1;
            hw_in     = v1_ff ? w1_ff : agent_idx;
            cnt_in    = cnt_ff + CNT_BITS'(1);
         end
      end else begin
         priority if (own_ff == '0) begin
            status_in = bktl_pkg::ST_NO_TICKET;
         end else if (!v1_ff || (IDX_W'(w1_ff) != IDX_W'(agent_ff))) begin
            status_in = bktl_pkg::ST_NOT_HOLDER;
         end else begin
            do_write = 1'b1;
            hv_in    = v2_ff;
            hw_in    = v2_ff ? w2_ff : '0;
            cnt_in   = cnt_ff - CNT_BITS'(1);
         end
      end
      hw_wide  = hv_in ? 8'(hw_in) : '0;
      cnt_wide = 8'(cnt_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= bktl_pkg::CFG_RESET;
         vld_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            cfg_ff <= csr_data;
         end
         rd_pend_ff <= cmd.scan;
         if (cmd.decide && do_write) begin
            vld_ff[agent_idx] <= (op_ff == bktl_pkg::OP_REQUEST);
         end
         if (cmd.decide) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff    <= req_op;
         agent_ff <= req_agent;
         idx_ff   <= '0;
      end else if (cmd.scan) begin
         idx_ff <= idx_ff + AGENT_BITS'(1);
      end
      if (cmd.scan) begin
         rd_idx_ff <= idx_ff;
         rd_vld_ff <= vld_ff[idx_ff];
      end
      if (cmd.start) begin
         max_ff <= '0;
         cnt_ff <= '0;
         v1_ff  <= 1'b0;
         t1_ff  <= '0;
         w1_ff  <= '0;
         v2_ff  <= 1'b0;
         t2_ff  <= '0;
         w2_ff  <= '0;
         own_ff <= '0;
      end else if (rd_pend_ff) begin
         if (cur_t > max_ff) begin
            max_ff <= cur_t;
         end
         if (IDX_W'(rd_idx_ff) == IDX_W'(agent_ff)) begin
            own_ff <= cur_t;
         end
         if (cur_t != '0) begin
            cnt_ff <= cnt_ff + CNT_BITS'(1);
            priority if (!v1_ff || (cur_t < t1_ff)) begin
               v1_ff <= 1'b1;
               t1_ff <= cur_t;
               w1_ff <= rd_idx_ff;
               v2_ff <= v1_ff;
               t2_ff <= t1_ff;
               w2_ff <= w1_ff;
            end else if (!v2_ff || (cur_t < t2_ff)) begin
               v2_ff <= 1'b1;
               t2_ff <= cur_t;
               w2_ff <= rd_idx_ff;
            end else begin
               v2_ff <= v2_ff;
            end
         end
      end
      if (cmd.decide) begin
         status_ff <= status_in;
         ticket_ff <= give_wide[bktl_pkg::TICKET_W-1:0];
         hv_ff     <= hv_in;
         holder_ff <= hw_wide[bktl_pkg::HOLDER_W-1:0];
         count_ff  <= cnt_wide[bktl_pkg::COUNT_W-1:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_ticket        = ticket_ff;
   assign rsp_holder_valid  = hv_ff;
   assign rsp_holder        = holder_ff;
   assign rsp_waiting_count = count_ff;

endmodule
`default_nettype wire

>>> hdl/bakery_ticket_lock_arbiter.sv
// Items are handled one at a time: the controller scans every ticket through the single
// read port of the ticket RAM, then passes the last-read and decide states before it
// returns to idle and accepts the next item.
// A new item is taken while the previous result waits in the output register.
// Reset (synchronous, active high) clears all tickets through per-agent valid
// bits at once and sets agents_in_use to 8; no clearing pass is needed.
`default_nettype none
`include "bakery_ticket_lock_arbiter_macros.svh"
module bakery_ticket_lock_arbiter #(
   parameter int MAX_AGENTS  = bktl_pkg::MAX_AGENTS_DEF,
   parameter int TICKET_BITS = bktl_pkg::TICKET_BITS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   bktl_req_if.sink   req_if,
   bktl_rsp_if.source rsp_if,
   bktl_csr_if.sink   csr_if
);

   bktl_pkg::cmd_type  cmd;
   bktl_pkg::stat_type stat;

   bktl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bktl_dp #(
      .MAX_AGENTS  (MAX_AGENTS),
      .TICKET_BITS (TICKET_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_op            (req_if.op),
      .req_agent         (req_if.agent),
      .csr_valid         (csr_if.valid),
      .csr_ready         (csr_if.ready),
      .csr_data          (csr_if.data),
      .rsp_ready         (rsp_if.ready),
      .rsp_valid         (rsp_if.valid),
      .rsp_status        (rsp_if.status),
      .rsp_ticket        (rsp_if.ticket),
      .rsp_holder_valid  (rsp_if.holder_valid),
      .rsp_holder        (rsp_if.holder),
      .rsp_waiting_count (rsp_if.waiting_count)
   );

   `BKTL_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_if.valid && req_if.ready, !req_if.ready, "item accepted while busy")
   `BKTL_ASSERT_NOW(a_decide_free, clock, reset, cmd.decide, stat.out_free, "result overwrites unsent result")
   `BKTL_ASSERT_NOW(a_no_holder, clock, reset, rsp_if.valid && !rsp_if.holder_valid, (rsp_if.holder == '0) && (rsp_if.waiting_count == '0), "holder or count set without holder")
   `BKTL_ASSERT_NOW(a_reject_ticket, clock, reset, rsp_if.valid && (rsp_if.status != bktl_pkg::ST_OK), rsp_if.ticket == '0, "ticket given on rejected item")

endmodule
`default_nettype wire

>>> dv/tb_bakery_ticket_lock_arbiter.sv
`timescale 1ns / 1ps
module tb_bakery_ticket_lock_arbiter;

   localparam int NUM_AGENTS = bktl_pkg::MAX_AGENTS_DEF;
   localparam int LATENCY    = bktl_pkg::MAX_AGENTS_DEF + 3;

   typedef logic [bktl_pkg::TICKET_W-1:0] ticket_type;

   typedef struct packed {
      logic [bktl_pkg::STATUS_W-1:0] status;
      ticket_type                    ticket;
      logic                          holder_valid;
      logic [bktl_pkg::HOLDER_W-1:0] holder;
      logic [bktl_pkg::COUNT_W-1:0]  waiting_count;
   } lock_outcome_type;

   class ticket_ledger;
      ticket_type                 tickets[NUM_AGENTS];
      logic [bktl_pkg::CFG_W-1:0] agents_in_use;
      lock_outcome_type           pending_outcomes[$];
      int                         errors;

      function new();
         foreach (tickets[a]) tickets[a] = '0;
         agents_in_use = bktl_pkg::CFG_RESET;
         errors = 0;
      endfunction

      function int limit();
         return (agents_in_use > NUM_AGENTS) ? NUM_AGENTS : int'(agents_in_use);
      endfunction

      function int pending();
         return pending_outcomes.size();
      endfunction

      function void survey(output bit found, output int who, output ticket_type top,
                           output int count);
         found = 1'b0;
         who = 0;
         top = '0;
         count = 0;
         for (int a = 0; a < NUM_AGENTS; a++) begin
            if (tickets[a] > top) top = tickets[a];
            if (tickets[a] != '0) begin
               count++;
               if (!found || tickets[a] < tickets[who]) begin
                  found = 1'b1;
                  who = a;
               end
            end
         end
      endfunction

      function void holder_now(output bit found, output int who);
         ticket_type top;
         int count;
         survey(found, who, top, count);
      endfunction

      function int free_agent();
         int start, a;
         start = $urandom_range(NUM_AGENTS - 1);
         for (int k = 0; k < NUM_AGENTS; k++) begin
            a = (start + k) % NUM_AGENTS;
            if (a < limit() && tickets[a] == '0) return a;
         end
         return -1;
      endfunction

      function void apply_event(logic [bktl_pkg::OP_W-1:0] op,
                                logic [bktl_pkg::AGENT_W-1:0] agent);
         lock_outcome_type o;
         bit found;
         int who, count;
         ticket_type top;
         o = '0;
         o.status = bktl_pkg::ST_OK;
         survey(found, who, top, count);
         if (agent >= limit()) begin
            o.status = bktl_pkg::ST_BAD_AGENT;
         end else if (op == bktl_pkg::OP_REQUEST) begin
            if (tickets[agent] != '0) begin
               o.status = bktl_pkg::ST_ALREADY;
            end else if (top == '1) begin
               o.status = bktl_pkg::ST_OVERFLOW;
            end else begin
               o.ticket = top + 1'b1;
               tickets[agent] = o.ticket;
            end
         end else if (tickets[agent] == '0) begin
            o.status = bktl_pkg::ST_NO_TICKET;
         end else if (!found || who != agent) begin
            o.status = bktl_pkg::ST_NOT_HOLDER;
         end else begin
            tickets[agent] = '0;
         end
         survey(found, who, top, count);
         o.holder_valid = found;
         o.holder = found ? who[bktl_pkg::HOLDER_W-1:0] : '0;
         o.waiting_count = count[bktl_pkg::COUNT_W-1:0];
         pending_outcomes.push_back(o);
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
         errors++;
      endtask

      task check_result(logic [bktl_pkg::STATUS_W-1:0] status, ticket_type ticket,
                        logic holder_valid, logic [bktl_pkg::HOLDER_W-1:0] holder,
                        logic [bktl_pkg::COUNT_W-1:0] waiting_count);
         lock_outcome_type want;
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected item, status", status, 0);
            return;
         end
         want = pending_outcomes.pop_front();
         if (status !== want.status) report_mismatch("status", status, want.status);
         if (ticket !== want.ticket) report_mismatch("ticket", ticket, want.ticket);
         if (holder_valid !== want.holder_valid)
            report_mismatch("holder_valid", holder_valid, want.holder_valid);
         if (holder !== want.holder) report_mismatch("holder", holder, want.holder);
         if (waiting_count !== want.waiting_count)
            report_mismatch("waiting_count", waiting_count, want.waiting_count);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   bktl_req_if req_ch ();
   bktl_rsp_if rsp_ch ();
   bktl_csr_if csr_ch ();

   ticket_ledger ledger;
   int req_idle_pct = 14;
   int rsp_idle_pct = 14;
   int rsp_hold_left = 0;

   bakery_ticket_lock_arbiter DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always #2 clock = ~clock;

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         ledger.check_result(rsp_ch.status, rsp_ch.ticket, rsp_ch.holder_valid,
                             rsp_ch.holder, rsp_ch.waiting_count);
   end

   initial begin
      #60000000;
      $display("tb_bakery_ticket_lock_arbiter NOT OK");
      $finish;
   end

   task automatic offer_event(input logic [bktl_pkg::OP_W-1:0] op,
                              input logic [bktl_pkg::AGENT_W-1:0] agent);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.agent <= agent;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      ledger.apply_event(op, agent);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (ledger.pending() != 0);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_agents_in_use(input logic [bktl_pkg::CFG_W-1:0] value);
      drain_results();
      csr_ch.valid <= 1'b1;
      csr_ch.data <= value;
      @(posedge clock);
      while (csr_ch.ready !== 1'b1) @(posedge clock);
      ledger.agents_in_use = value;
      csr_ch.valid <= 1'b0;
   endtask

   task automatic release_all();
      bit found;
      int who;
      ledger.holder_now(found, who);
      while (found && who < ledger.limit()) begin
         offer_event(bktl_pkg::OP_RELEASE, who[bktl_pkg::AGENT_W-1:0]);
         ledger.holder_now(found, who);
      end
   endtask

   task automatic run_directed();
      offer_event(bktl_pkg::OP_RELEASE, 3'd0);
      offer_event(bktl_pkg::OP_REQUEST, 3'd0);
      offer_event(bktl_pkg::OP_REQUEST, 3'd0);
      offer_event(bktl_pkg::OP_REQUEST, 3'd7);
      offer_event(bktl_pkg::OP_RELEASE, 3'd7);
      offer_event(bktl_pkg::OP_REQUEST, 3'd3);
      offer_event(bktl_pkg::OP_RELEASE, 3'd0);
      offer_event(bktl_pkg::OP_REQUEST, 3'd6);
      // agent 6 drops out of range but keeps its ticket
      write_agents_in_use(4'd3);
      offer_event(bktl_pkg::OP_REQUEST, 3'd5);
      offer_event(bktl_pkg::OP_RELEASE, 3'd6);
      offer_event(bktl_pkg::OP_REQUEST, 3'd1);
      offer_event(bktl_pkg::OP_RELEASE, 3'd3);
      write_agents_in_use(4'd0);
      offer_event(bktl_pkg::OP_REQUEST, 3'd0);
      offer_event(bktl_pkg::OP_RELEASE, 3'd0);
      write_agents_in_use(4'd15);
      offer_event(bktl_pkg::OP_REQUEST, 3'd7);
      release_all();
   endtask

   task automatic run_random(input logic [bktl_pkg::CFG_W-1:0] cfg, input int count,
                             input int idle_pct, input bit hold_off, input bit pause);
      int choice, a, who;
      bit found;
      write_agents_in_use(cfg);
      req_idle_pct = idle_pct;
      rsp_idle_pct = idle_pct;
      for (int i = 0; i < count; i++) begin
         if (hold_off && i == count / 3) rsp_hold_left = 400;
         if (pause && i == count / 2) drain_results();
         choice = $urandom_range(99);
         a = ledger.free_agent();
         ledger.holder_now(found, who);
         if (choice < 45 && a >= 0)
            offer_event(bktl_pkg::OP_REQUEST, a[bktl_pkg::AGENT_W-1:0]);
         else if (choice < 80 && found && who < ledger.limit())
            offer_event(bktl_pkg::OP_RELEASE, who[bktl_pkg::AGENT_W-1:0]);
         else
            offer_event(bktl_pkg::OP_W'($urandom_range(1)),
                        bktl_pkg::AGENT_W'($urandom_range(7)));
      end
      release_all();
   endtask

   initial begin
      ledger = new();
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.op <= bktl_pkg::OP_REQUEST;
      req_ch.agent <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.data <= bktl_pkg::CFG_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      run_random(4'd8, 300, 14, 1'b0, 1'b0);
      run_random(4'd3, 200, 0, 1'b0, 1'b0);
      run_random(4'd1, 120, 14, 1'b0, 1'b0);
      run_random(4'd0, 30, 14, 1'b0, 1'b0);
      run_random(4'd15, 250, 14, 1'b1, 1'b0);
      run_random(4'd5, 200, 14, 1'b0, 1'b1);
      run_random(4'd12, 150, 14, 1'b0, 1'b0);
      run_random(4'd2, 100, 14, 1'b0, 1'b0);
      run_random(4'd8, 100, 14, 1'b0, 1'b0);

      drain_results();
      if (ledger.errors == 0 && ledger.pending() == 0)
         $display("tb_bakery_ticket_lock_arbiter OK");
      else
         $display("tb_bakery_ticket_lock_arbiter NOT OK");
      $finish;
   end

endmodule

>>> bakery_ticket_lock_arbiter.f
+incdir+hdl
hdl/bktl_pkg.sv
hdl/bktl_channels.sv
hdl/bktl_ram.sv
hdl/bktl_ctrl.sv
hdl/bktl_dp.sv
hdl/bakery_ticket_lock_arbiter.sv
dv/tb_bakery_ticket_lock_arbiter.sv
